/* sv/dvrtp_pkg.sv */
// Shared types, codes and constants of the DV DIF RTP packetizer.
// No dependencies; imported by every module of the block.
package dvrtp_pkg;

    localparam int DEF_MAX_BLOCKS = 18;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [31:0] TS_STEP       = 32'd3003;
    localparam logic [7:0]  LAST_DBN      = 8'd134;
    localparam logic [3:0]  NTSC_LAST_SEQ = 4'd9;
    localparam logic [3:0]  PAL_LAST_SEQ  = 4'd11;
    localparam logic [3:0]  MAX_REDUND    = 4'd8;

    // section types
    localparam logic [2:0] SCT_AUDIO = 3'd3;
    localparam logic [2:0] SCT_VIDEO = 3'd4;

    // video formats (stream_mode bits 3-4)
    localparam logic [1:0] FMT_NTSC = 2'd0;
    localparam logic [1:0] FMT_PAL  = 2'd1;

    // result actions
    localparam logic [1:0] ACT_PLACE  = 2'd0;
    localparam logic [1:0] ACT_SEND   = 2'd1;
    localparam logic [1:0] ACT_DROP   = 2'd2;
    localparam logic [1:0] ACT_REJECT = 2'd3;

    // result streams
    localparam logic [1:0] STR_MAIN  = 2'd0;
    localparam logic [1:0] STR_AUDIO = 2'd1;
    localparam logic [1:0] STR_REDUN = 2'd2;

    // register indexes
    localparam logic [2:0] REG_BPP       = 3'd0;
    localparam logic [2:0] REG_DROP      = 3'd1;
    localparam logic [2:0] REG_REDUN     = 3'd2;
    localparam logic [2:0] REG_MODE      = 3'd3;
    localparam logic [2:0] REG_MSEQ      = 3'd4;
    localparam logic [2:0] REG_ASEQ      = 3'd5;
    localparam logic [2:0] REG_MTS       = 3'd6;
    localparam logic [2:0] REG_ATS       = 3'd7;

    typedef enum logic [1:0] {
        K_REJECT = 2'd0,
        K_MAIN   = 2'd1,
        K_AUDIO  = 2'd2,
        K_VIDEO  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind kind;
        logic  end_frame;
    } t_desc;

    typedef struct packed {
        logic [4:0] bpp;
        logic [7:0] drop_ratio;
        logic [3:0] redundancy;
        logic [4:0] mode;
    } t_cfg;

    typedef struct packed {
        logic        valid;
        logic [2:0]  idx;
        logic [31:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic [1:0]  action;
        logic [1:0]  stream;
        logic [4:0]  slot;
        logic [4:0]  blocks;
        logic [15:0] seq;
        logic [31:0] ts;
        logic        last;
    } t_result;

endpackage

/* sv/dv_dif_rtp_packetizer_top.sv */
// Top level of the DV DIF RTP packetizer: APB register file, front end,
// descriptor queue and sequencer. Depends on dvrtp_pkg and all dvrtp_* modules.
//
//  channel   | direction | handshake                 | content
//  ----------+-----------+---------------------------+------------------------------
//  s_axis    | in        | tvalid/tready             | DIF block ID request
//  m_axis    | out       | tvalid/tready, tlast      | place/send/drop/reject result
//  apb       | in        | psel/penable/pwrite/pready| 8 registers at 4*i, 32 bit
//
//  Every request produces 1 to 11 results; the sequencer emits one result per
//  cycle while the output register can take it.
//  Front end and sequencer are split by a 2-entry queue: requests keep flowing
//  in while results are stalled until the queue fills. Results sit in an
//  output register; the sequencer advances only when that register is empty or
//  being taken, so a waiting result holds it, yet unstalled results flow at one
//  per cycle. Reset (synchronous, active low) clears counters, fills and the queue.
module dv_dif_rtp_packetizer_top
    import dvrtp_pkg::*;
#(
    parameter int MAX_BLOCKS_PER_PACKET = DEF_MAX_BLOCKS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [2:0] section_type, [6:3] dif_sequence,
                                          // [14:7] block_number, [15] zero
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // [1:0] action, [3:2] stream, [8:4] slot,
                                          // [13:9] packet_blocks, [29:14] seq_number,
                                          // [61:30] timestamp, [63:62] zero
    output logic        o_m_axis_tlast,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // configuration registers
    logic [4:0]  r_bpp;
    logic [7:0]  r_drop_ratio;
    logic [3:0]  r_redundancy;
    logic [4:0]  r_mode;
    logic [15:0] r_mseq_start;
    logic [15:0] r_aseq_start;
    logic [31:0] r_mts_start;
    logic [31:0] r_ats_start;

    t_cfg    cfg;
    t_cfg_wr cfg_wr;
    logic [2:0] reg_idx;

    logic    q_push, q_full, q_pop, q_valid;
    t_desc   q_in_desc, q_out_desc;
    t_result out_res;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];

    assign cfg_wr.valid = psel && penable && pwrite && pready;
    assign cfg_wr.idx   = reg_idx;
    assign cfg_wr.data  = pwdata;

    assign cfg.bpp        = r_bpp;
    assign cfg.drop_ratio = r_drop_ratio;
    assign cfg.redundancy = r_redundancy;
    assign cfg.mode       = r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpp        <= 5'd1;
            r_drop_ratio <= 8'd1;
            r_redundancy <= '0;
            r_mode       <= '0;
            r_mseq_start <= '0;
            r_aseq_start <= '0;
            r_mts_start  <= '0;
            r_ats_start  <= '0;
        end else if (cfg_wr.valid) begin
            unique case (reg_idx)
                REG_BPP:   r_bpp        <= pwdata[4:0];
                REG_DROP:  r_drop_ratio <= pwdata[7:0];
                REG_REDUN: r_redundancy <= pwdata[3:0];
                REG_MODE:  r_mode       <= pwdata[4:0];
                REG_MSEQ:  r_mseq_start <= pwdata[15:0];
                REG_ASEQ:  r_aseq_start <= pwdata[15:0];
                REG_MTS:   r_mts_start  <= pwdata;
                REG_ATS:   r_ats_start  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_BPP:   prdata = {27'd0, r_bpp};
            REG_DROP:  prdata = {24'd0, r_drop_ratio};
            REG_REDUN: prdata = {28'd0, r_redundancy};
            REG_MODE:  prdata = {27'd0, r_mode};
            REG_MSEQ:  prdata = {16'd0, r_mseq_start};
            REG_ASEQ:  prdata = {16'd0, r_aseq_start};
            REG_MTS:   prdata = r_mts_start;
            REG_ATS:   prdata = r_ats_start;
            default:   prdata = '0;
        endcase
    end

    dvrtp_front u_front (
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_mode          (r_mode),
        .i_q_full        (q_full),
        .o_q_push        (q_push),
        .o_q_desc        (q_in_desc)
    );

    dvrtp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_desc  (q_in_desc),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_desc  (q_out_desc)
    );

    dvrtp_back #(
        .MAX_BLOCKS (MAX_BLOCKS_PER_PACKET)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cfg_wr    (cfg_wr),
        .i_q_valid   (q_valid),
        .i_q_desc    (q_out_desc),
        .o_q_pop     (q_pop),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out       (out_res)
    );

    assign o_m_axis_tdata = {2'b00, out_res.ts, out_res.seq, out_res.blocks,
                             out_res.slot, out_res.stream, out_res.action};
    assign o_m_axis_tlast = out_res.last;

endmodule

/* sv/dvrtp_front.sv */
// Front end: takes DIF block IDs and classifies them into work descriptors.
// Depends on dvrtp_pkg; feeds dvrtp_queue.
module dvrtp_front
    import dvrtp_pkg::*;
(
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [2:0] section_type, [6:3] dif_sequence,
                                          // [14:7] block_number
    input  logic [4:0]  i_mode,
    input  logic        i_q_full,
    output logic        o_q_push,
    output t_desc       o_q_desc
);

    logic [2:0] sct;
    logic [3:0] dseq;
    logic [7:0] dbn;
    logic [1:0] fmt;

    assign sct  = i_s_axis_tdata[2:0];
    assign dseq = i_s_axis_tdata[6:3];
    assign dbn  = i_s_axis_tdata[14:7];
    assign fmt  = i_mode[4:3];

    assign o_s_axis_tready = !i_q_full;
    assign o_q_push        = i_s_axis_tvalid && !i_q_full;

    always_comb begin
        o_q_desc.end_frame = 1'b0;
        if (sct > SCT_VIDEO) begin
            o_q_desc.kind = K_REJECT;
        end else if (sct < SCT_AUDIO) begin
            o_q_desc.kind = K_MAIN;
        end else if (sct == SCT_AUDIO) begin
            o_q_desc.kind = K_AUDIO;
        end else begin
            o_q_desc.kind = K_VIDEO;
            // last video block of a frame
            o_q_desc.end_frame = (dbn == LAST_DBN) &&
                ((fmt == FMT_NTSC && dseq == NTSC_LAST_SEQ) ||
                 (fmt == FMT_PAL  && dseq == PAL_LAST_SEQ));
        end
    end

endmodule

/* sv/dvrtp_queue.sv */
// Short descriptor queue between front end and sequencer.
// Depends on dvrtp_pkg.
module dvrtp_queue
    import dvrtp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_desc i_desc,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_desc o_desc
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_desc            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_desc  = r_mem[r_rd_ptr];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= ptr_inc(r_wr_ptr);
            if (i_pop)  r_rd_ptr <= ptr_inc(r_rd_ptr);
            if (i_push && !i_pop)      r_count <= r_count + CNT_W'(1);
            else if (!i_push && i_pop) r_count <= r_count - CNT_W'(1);
        end
    end

endmodule

/* sv/dvrtp_back.sv */
// Sequencer: runs each descriptor as place/send/drop/reject results, one per cycle
// unless output stalls; owns fills, RTP counters, frame phase. Depends on dvrtp_pkg.
module dvrtp_back
    import dvrtp_pkg::*;
#(
    parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  t_cfg_wr i_cfg_wr,
    input  logic    i_q_valid,
    input  t_desc   i_q_desc,
    output logic    o_q_pop,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_result o_out
);

    typedef enum logic [5:0] {
        ST_PRIM   = 6'b000001,
        ST_SEND   = 6'b000010,
        ST_RPLACE = 6'b000100,
        ST_RSEND  = 6'b001000,
        ST_EFM    = 6'b010000,
        ST_EFA    = 6'b100000
    } t_bstate;

    t_bstate     r_state, n_state;
    logic        r_sel_audio, n_sel_audio;
    logic [4:0]  r_main_fill, n_main_fill;
    logic [4:0]  r_audio_fill, n_audio_fill;
    logic [4:0]  r_red_fill, n_red_fill;
    logic [3:0]  r_rep_cnt, n_rep_cnt;
    logic [15:0] r_main_seq, n_main_seq;
    logic [15:0] r_audio_seq, n_audio_seq;
    logic [31:0] r_main_ts, n_main_ts;
    logic [31:0] r_audio_ts, n_audio_ts;
    logic [7:0]  r_phase, n_phase;
    logic        r_out_valid;
    t_result     r_out;
    t_result     res;

    logic       step, done, dropped, ratio_gt1, sep_audio, end_frame;
    logic [4:0] limit;
    logic [3:0] reps;
    logic       main_full, audio_full, red_full;
    logic [8:0] phase_next;
    t_bstate    ef_audio_next;

    always_comb begin
        if (i_cfg.bpp == 5'd0) begin
            limit = 5'd1;
        end else if (int'(i_cfg.bpp) > MAX_BLOCKS) begin
            limit = 5'(MAX_BLOCKS);
        end else begin
            limit = i_cfg.bpp;
        end
    end

    assign reps       = (i_cfg.redundancy > MAX_REDUND) ? MAX_REDUND : i_cfg.redundancy;
    assign ratio_gt1  = (i_cfg.drop_ratio > 8'd1);
    assign dropped    = ratio_gt1 && (r_phase != 8'd0);
    assign sep_audio  = i_cfg.mode[2];
    assign end_frame  = i_q_desc.end_frame;
    assign main_full  = ({1'b0, r_main_fill}  + 6'd1) >= {1'b0, limit};
    assign audio_full = ({1'b0, r_audio_fill} + 6'd1) >= {1'b0, limit};
    assign red_full   = ({1'b0, r_red_fill}   + 6'd1) >= {1'b0, limit};
    assign phase_next = {1'b0, r_phase} + 9'd1;
    assign ef_audio_next = (end_frame && sep_audio && r_audio_fill != 5'd0) ? ST_EFA : ST_PRIM;

    // one result per cycle whenever the output stage can take it
    assign step = i_q_valid && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state      = r_state;
        n_sel_audio  = r_sel_audio;
        n_main_fill  = r_main_fill;
        n_audio_fill = r_audio_fill;
        n_red_fill   = r_red_fill;
        n_rep_cnt    = r_rep_cnt;
        n_main_seq   = r_main_seq;
        n_audio_seq  = r_audio_seq;
        n_main_ts    = r_main_ts;
        n_audio_ts   = r_audio_ts;
        n_phase      = r_phase;
        res          = '0;

        unique case (r_state)
            ST_PRIM: begin
                unique case (i_q_desc.kind)
                    K_REJECT: begin
                        res.action = ACT_REJECT;
                        n_state    = ST_PRIM;
                    end
                    K_MAIN: begin
                        if (dropped) begin
                            res.action = ACT_DROP;
                            n_state    = ST_PRIM;
                        end else begin
                            res.action  = ACT_PLACE;
                            res.stream  = STR_MAIN;
                            res.slot    = r_main_fill;
                            n_main_fill = r_main_fill + 5'd1;
                            n_sel_audio = 1'b0;
                            n_state     = main_full ? ST_SEND : ST_PRIM;
                        end
                    end
                    K_AUDIO: begin
                        if (!i_cfg.mode[1]) begin
                            res.action  = ACT_PLACE;
                            n_sel_audio = sep_audio;
                            if (sep_audio) begin
                                res.stream   = STR_AUDIO;
                                res.slot     = r_audio_fill;
                                n_audio_fill = r_audio_fill + 5'd1;
                            end else begin
                                res.stream  = STR_MAIN;
                                res.slot    = r_main_fill;
                                n_main_fill = r_main_fill + 5'd1;
                            end
                            if (sep_audio ? audio_full : main_full) begin
                                n_state = ST_SEND;
                            end else if (i_cfg.redundancy != 4'd0) begin
                                n_state = ST_RPLACE;
                            end else begin
                                n_state = ST_PRIM;
                            end
                        end else if (i_cfg.redundancy != 4'd0) begin
                            // redundancy buffer only
                            res.action = ACT_PLACE;
                            res.stream = STR_REDUN;
                            res.slot   = r_red_fill;
                            n_red_fill = r_red_fill + 5'd1;
                            n_rep_cnt  = reps;
                            n_state    = red_full ? ST_RSEND : ST_PRIM;
                        end else begin
                            res.action = ACT_DROP;
                            n_state    = ST_PRIM;
                        end
                    end
                    K_VIDEO: begin
                        n_sel_audio = 1'b0;
                        if (i_cfg.mode[0] || dropped) begin
                            res.action = ACT_DROP;
                            n_state    = (end_frame && r_main_fill != 5'd0) ? ST_EFM
                                                                            : ef_audio_next;
                        end else begin
                            res.action  = ACT_PLACE;
                            res.stream  = STR_MAIN;
                            res.slot    = r_main_fill;
                            n_main_fill = r_main_fill + 5'd1;
                            if (main_full) begin
                                n_state = ST_SEND;
                            end else if (end_frame) begin
                                n_state = ST_EFM;   // fill is nonzero after the place
                            end else begin
                                n_state = ST_PRIM;
                            end
                        end
                    end
                    default: n_state = ST_PRIM;
                endcase
            end
            ST_SEND: begin
                res.action = ACT_SEND;
                if (r_sel_audio) begin
                    res.stream   = STR_AUDIO;
                    res.blocks   = r_audio_fill;
                    res.seq      = r_audio_seq;
                    res.ts       = r_audio_ts;
                    n_audio_fill = 5'd0;
                    n_audio_seq  = r_audio_seq + 16'd1;
                end else begin
                    res.stream  = STR_MAIN;
                    res.blocks  = r_main_fill;
                    res.seq     = r_main_seq;
                    res.ts      = r_main_ts;
                    n_main_fill = 5'd0;
                    n_main_seq  = r_main_seq + 16'd1;
                end
                if (i_q_desc.kind == K_AUDIO && i_cfg.redundancy != 4'd0) begin
                    n_state = ST_RPLACE;
                end else begin
                    n_state = ef_audio_next;
                end
            end
            ST_RPLACE: begin
                res.action = ACT_PLACE;
                res.stream = STR_REDUN;
                res.slot   = r_red_fill;
                n_red_fill = r_red_fill + 5'd1;
                n_rep_cnt  = reps;
                n_state    = red_full ? ST_RSEND : ST_PRIM;
            end
            ST_RSEND: begin
                // redundant copies ride on the main counters
                res.action = ACT_SEND;
                res.stream = STR_REDUN;
                res.blocks = r_red_fill;
                res.seq    = r_main_seq;
                res.ts     = r_main_ts;
                n_main_seq = r_main_seq + 16'd1;
                n_rep_cnt  = r_rep_cnt - 4'd1;
                if (r_rep_cnt <= 4'd1) begin
                    n_red_fill = 5'd0;
                    n_state    = ST_PRIM;
                end
            end
            ST_EFM: begin
                res.action  = ACT_SEND;
                res.stream  = STR_MAIN;
                res.blocks  = r_main_fill;
                res.seq     = r_main_seq;
                res.ts      = r_main_ts;
                n_main_fill = 5'd0;
                n_main_seq  = r_main_seq + 16'd1;
                n_state     = ef_audio_next;
            end
            ST_EFA: begin
                res.action   = ACT_SEND;
                res.stream   = STR_AUDIO;
                res.blocks   = r_audio_fill;
                res.seq      = r_audio_seq;
                res.ts       = r_audio_ts;
                n_audio_fill = 5'd0;
                n_audio_seq  = r_audio_seq + 16'd1;
                n_state      = ST_PRIM;
            end
            default: n_state = ST_PRIM;
        endcase

        done     = (n_state == ST_PRIM);
        res.last = done;

        // frame end bookkeeping on the item's final result
        if (done && end_frame) begin
            n_main_ts = r_main_ts + TS_STEP;
            n_phase   = (ratio_gt1 && phase_next < {1'b0, i_cfg.drop_ratio})
                        ? phase_next[7:0] : 8'd0;
            if (sep_audio) begin
                n_audio_ts = r_audio_ts + TS_STEP;
            end
        end
    end

    assign o_q_pop     = step && done;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_PRIM;
            r_sel_audio  <= 1'b0;
            r_main_fill  <= '0;
            r_audio_fill <= '0;
            r_red_fill   <= '0;
            r_rep_cnt    <= '0;
            r_main_seq   <= '0;
            r_audio_seq  <= '0;
            r_main_ts    <= '0;
            r_audio_ts   <= '0;
            r_phase      <= '0;
        end else if (i_cfg_wr.valid) begin
            unique case (i_cfg_wr.idx)
                REG_DROP: r_phase     <= (i_cfg_wr.data[7:0] > 8'd1) ? 8'd1 : 8'd0;
                REG_MSEQ: r_main_seq  <= i_cfg_wr.data[15:0];
                REG_ASEQ: r_audio_seq <= i_cfg_wr.data[15:0];
                REG_MTS:  r_main_ts   <= i_cfg_wr.data;
                REG_ATS:  r_audio_ts  <= i_cfg_wr.data;
                default: ;
            endcase
        end else if (step) begin
            r_state      <= n_state;
            r_sel_audio  <= n_sel_audio;
            r_main_fill  <= n_main_fill;
            r_audio_fill <= n_audio_fill;
            r_red_fill   <= n_red_fill;
            r_rep_cnt    <= n_rep_cnt;
            r_main_seq   <= n_main_seq;
            r_audio_seq  <= n_audio_seq;
            r_main_ts    <= n_main_ts;
            r_audio_ts   <= n_audio_ts;
            r_phase      <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= res;
        end
    end

endmodule

/* verif/tb_dv_dif_rtp_packetizer_top.sv */
// Testbench of dv_dif_rtp_packetizer_top: DIF block IDs in, slot/packet results out,
// checked against a cycle-free model of the sequencer. Depends on dvrtp_pkg and the RTL.
`timescale 1ns / 1ps

module tb_dv_dif_rtp_packetizer_top;
    import dvrtp_pkg::*;

    // section types not named in the package
    localparam logic [2:0] SCT_HEADER  = 3'd0;
    localparam logic [2:0] SCT_SUBCODE = 3'd1;
    localparam logic [2:0] SCT_VAUX    = 3'd2;
    localparam logic [2:0] SCT_BAD_LO  = 3'd5;
    localparam logic [2:0] SCT_BAD_MID = 3'd6;
    localparam logic [2:0] SCT_BAD_HI  = 3'd7;

    // stream_mode bits
    localparam int MODE_NO_VIDEO = 0;
    localparam int MODE_NO_AUDIO = 1;
    localparam int MODE_SEP_AUD  = 2;
    localparam logic [1:0] FMT_NONE   = 2'd2;
    localparam logic [1:0] FMT_NONE_B = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    dv_dif_rtp_packetizer_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Packetizer model: register copies and sequencing state
    // ------------------------------------------------------------------
    logic [4:0]  cfg_bpp   = 5'd1;
    logic [7:0]  cfg_drop  = 8'd1;
    logic [3:0]  cfg_redun = 4'd0;
    logic [4:0]  cfg_mode  = 5'd0;
    logic [4:0]  main_fill = '0, audio_fill = '0, redun_fill = '0;
    logic [15:0] main_seq = '0, audio_seq = '0;
    logic [31:0] main_ts = '0, audio_ts = '0;
    logic [7:0]  frame_phase = '0;

    t_result predicted_results[$];
    int      mismatch_count = 0;
    bit      send_gaps = 1'b0;     // sender idles in bursts
    bit      sink_stalls = 1'b0;   // receiver stalls in bursts

    function automatic void note_result(logic [1:0] act, logic [1:0] str, logic [4:0] slot,
                                        logic [4:0] blocks, logic [15:0] seq,
                                        logic [31:0] ts);
        t_result r;
        r.action = act;
        r.stream = str;
        r.slot   = slot;
        r.blocks = blocks;
        r.seq    = seq;
        r.ts     = ts;
        r.last   = 1'b0;
        predicted_results.push_back(r);
    endfunction

    // 0 behaves as 1, anything above the maximum saturates
    function automatic logic [4:0] packet_size();
        if (cfg_bpp == 5'd0) return 5'd1;
        if (cfg_bpp > DEF_MAX_BLOCKS) return 5'(DEF_MAX_BLOCKS);
        return cfg_bpp;
    endfunction

    function automatic bit frame_dropped();
        return (cfg_drop > 8'd1) && (frame_phase != 8'd0);
    endfunction

    function automatic void place_in_main();
        note_result(ACT_PLACE, STR_MAIN, main_fill, '0, '0, '0);
        main_fill++;
        if (main_fill >= packet_size()) begin
            note_result(ACT_SEND, STR_MAIN, '0, main_fill, main_seq, main_ts);
            main_fill = '0;
            main_seq++;
        end
    endfunction

    function automatic void place_in_audio();
        note_result(ACT_PLACE, STR_AUDIO, audio_fill, '0, '0, '0);
        audio_fill++;
        if (audio_fill >= packet_size()) begin
            note_result(ACT_SEND, STR_AUDIO, '0, audio_fill, audio_seq, audio_ts);
            audio_fill = '0;
            audio_seq++;
        end
    endfunction

    // a full redundancy packet goes out once per repeat, numbered on the main stream
    function automatic void place_in_redundant();
        logic [3:0] reps;
        reps = (cfg_redun > MAX_REDUND) ? MAX_REDUND : cfg_redun;
        note_result(ACT_PLACE, STR_REDUN, redun_fill, '0, '0, '0);
        redun_fill++;
        if (redun_fill >= packet_size()) begin
            for (int i = 0; i < reps; i++) begin
                note_result(ACT_SEND, STR_REDUN, '0, redun_fill, main_seq, main_ts);
                main_seq++;
            end
            redun_fill = '0;
        end
    endfunction

    function automatic void close_frame();
        int next_phase;
        if (main_fill > 0) begin
            note_result(ACT_SEND, STR_MAIN, '0, main_fill, main_seq, main_ts);
            main_fill = '0;
            main_seq++;
        end
        main_ts += TS_STEP;
        next_phase = int'(frame_phase) + 1;
        frame_phase = (cfg_drop > 8'd1 && next_phase < int'(cfg_drop)) ? 8'(next_phase) : 8'd0;
        if (cfg_mode[MODE_SEP_AUD]) begin
            if (audio_fill > 0) begin
                note_result(ACT_SEND, STR_AUDIO, '0, audio_fill, audio_seq, audio_ts);
                audio_fill = '0;
                audio_seq++;
            end
            audio_ts += TS_STEP;
        end
    endfunction

    function automatic void packetize_block(logic [2:0] sct, logic [3:0] dseq, logic [7:0] dbn);
        int  first;
        bit  placed;
        logic [1:0] fmt;
        first  = predicted_results.size();
        placed = 1'b0;
        fmt    = cfg_mode[4:3];
        if (sct > SCT_VIDEO) begin
            note_result(ACT_REJECT, STR_MAIN, '0, '0, '0, '0);
        end else if (sct < SCT_AUDIO) begin
            if (frame_dropped()) note_result(ACT_DROP, STR_MAIN, '0, '0, '0, '0);
            else place_in_main();
        end else if (sct == SCT_AUDIO) begin
            if (!cfg_mode[MODE_NO_AUDIO]) begin
                if (cfg_mode[MODE_SEP_AUD]) place_in_audio();
                else place_in_main();
                placed = 1'b1;
            end
            if (cfg_redun != 4'd0) begin
                place_in_redundant();
                placed = 1'b1;
            end
            if (!placed) note_result(ACT_DROP, STR_MAIN, '0, '0, '0, '0);
        end else begin
            if (cfg_mode[MODE_NO_VIDEO] || frame_dropped())
                note_result(ACT_DROP, STR_MAIN, '0, '0, '0, '0);
            else
                place_in_main();
            if (dbn == LAST_DBN && ((fmt == FMT_NTSC && dseq == NTSC_LAST_SEQ) ||
                                    (fmt == FMT_PAL && dseq == PAL_LAST_SEQ)))
                close_frame();
        end
        if (predicted_results.size() > first)
            predicted_results[predicted_results.size() - 1].last = 1'b1;
    endfunction

    function automatic void model_reg_write(logic [2:0] idx, logic [31:0] value);
        case (idx)
            REG_BPP:   cfg_bpp = value[4:0];
            REG_DROP: begin
                cfg_drop = value[7:0];
                frame_phase = (cfg_drop > 8'd1) ? 8'd1 : 8'd0;
            end
            REG_REDUN: cfg_redun = value[3:0];
            REG_MODE:  cfg_mode = value[4:0];
            REG_MSEQ:  main_seq = value[15:0];
            REG_ASEQ:  audio_seq = value[15:0];
            REG_MTS:   main_ts = value;
            REG_ATS:   audio_ts = value;
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Drivers. Everything changes at the falling edge; tasks start and end there.
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        model_reg_write(idx, value);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // one DIF ID request; the model runs at the accepting edge
    task automatic send_dif_id(input logic [2:0] sct, input logic [3:0] dseq,
                               input logic [7:0] dbn);
        if (send_gaps && $urandom_range(0, 3) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {1'b0, dbn, dseq, sct};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        packetize_block(sct, dseq, dbn);
        @(negedge i_clk);
        s_tvalid = 1'b0;
    endtask

    // hold off until every predicted result is out, then let the pipe settle
    task automatic wait_results_done(input int settle);
        s_tvalid = 1'b0;
        while (predicted_results.size() != 0) @(negedge i_clk);
        repeat (settle) @(negedge i_clk);
    endtask

    // receiver: ready, with stall bursts while enabled
    int stall_left = 0;
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_tready = 1'b0;
        end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 12) - 1;
            m_tready = 1'b0;
        end else begin
            m_tready = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Result checker: each accepted result against the oldest prediction
    // ------------------------------------------------------------------
    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got.action = m_tdata[1:0];
            got.stream = m_tdata[3:2];
            got.slot   = m_tdata[8:4];
            got.blocks = m_tdata[13:9];
            got.seq    = m_tdata[29:14];
            got.ts     = m_tdata[61:30];
            got.last   = m_tlast;
            if (predicted_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0h last %0b",
                         $time, m_tdata, m_tlast);
                mismatch_count++;
            end else begin
                want = predicted_results.pop_front();
                compare_field("action", want.action, got.action);
                compare_field("stream", want.stream, got.stream);
                compare_field("slot", want.slot, got.slot);
                compare_field("packet_blocks", want.blocks, got.blocks);
                compare_field("seq_number", want.seq, got.seq);
                compare_field("timestamp", want.ts, got.ts);
                compare_field("last", want.last, got.last);
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // reset values: one block per packet, nothing dropped, NTSC, shared audio
    task automatic test_reset_defaults();
        send_dif_id(SCT_HEADER, 4'd0, 8'd0);
        send_dif_id(SCT_SUBCODE, 4'd15, 8'd255);
        send_dif_id(SCT_BAD_HI, 4'd15, 8'd255);
        send_dif_id(SCT_BAD_LO, 4'd0, 8'd0);
        send_dif_id(SCT_BAD_MID, 4'd10, LAST_DBN);
        send_dif_id(SCT_VIDEO, NTSC_LAST_SEQ, LAST_DBN);
        send_dif_id(SCT_AUDIO, 4'd5, 8'd85);
    endtask

    // redundancy at its maximum with counters about to wrap; then saturation and off
    task automatic test_redundant_audio();
        wait_results_done(8);
        write_reg(REG_REDUN, 32'd8);
        write_reg(REG_BPP, 32'd2);
        write_reg(REG_MSEQ, 32'h0000_FFFE);
        write_reg(REG_MTS, 32'hFFFF_FFFF);
        send_dif_id(SCT_AUDIO, 4'd1, 8'd3);
        send_dif_id(SCT_AUDIO, 4'd2, 8'd4);    // full main and redundancy: 11 results
        wait_results_done(8);
        write_reg(REG_REDUN, 32'd15);
        write_reg(REG_MODE, 32'(1 << MODE_NO_AUDIO));
        send_dif_id(SCT_AUDIO, 4'd3, 8'd5);
        send_dif_id(SCT_AUDIO, 4'd4, 8'd6);
        wait_results_done(8);
        write_reg(REG_REDUN, 32'd0);
        send_dif_id(SCT_AUDIO, 4'd5, 8'd7);    // audio placed nowhere
    endtask

    // separate audio stream on PAL, audio counters near wrap, oversized packet size
    task automatic test_separate_audio();
        wait_results_done(8);
        write_reg(REG_MODE, {27'd0, FMT_PAL, 3'b100});
        write_reg(REG_ASEQ, 32'h0000_FFFF);
        write_reg(REG_ATS, 32'hFFFF_F000);
        write_reg(REG_BPP, 32'd31);
        send_dif_id(SCT_AUDIO, 4'd0, 8'd10);
        send_dif_id(SCT_HEADER, 4'd0, 8'd0);
        send_dif_id(SCT_VIDEO, PAL_LAST_SEQ, LAST_DBN);
        wait_results_done(8);
        // no video: the frame still ends, with nothing in the main buffer
        write_reg(REG_MODE, {27'd0, FMT_PAL, 3'b101});
        send_dif_id(SCT_VIDEO, PAL_LAST_SEQ, LAST_DBN);
    endtask

    // one frame in three kept; then ratio 0 and the formats that never end a frame
    task automatic test_frame_drop();
        wait_results_done(8);
        write_reg(REG_DROP, 32'd3);
        write_reg(REG_MODE, 32'd0);
        write_reg(REG_BPP, 32'd1);
        send_dif_id(SCT_HEADER, 4'd0, 8'd0);
        send_dif_id(SCT_VIDEO, NTSC_LAST_SEQ, LAST_DBN);
        send_dif_id(SCT_VAUX, 4'd3, 8'd1);
        send_dif_id(SCT_VIDEO, NTSC_LAST_SEQ, LAST_DBN);
        send_dif_id(SCT_HEADER, 4'd0, 8'd0);
        wait_results_done(8);
        write_reg(REG_DROP, 32'd0);
        write_reg(REG_MODE, {27'd0, FMT_NONE, 3'b000});
        send_dif_id(SCT_VIDEO, NTSC_LAST_SEQ, LAST_DBN);
        wait_results_done(8);
        write_reg(REG_MODE, {27'd0, FMT_NONE_B, 3'b000});
        send_dif_id(SCT_VIDEO, PAL_LAST_SEQ, LAST_DBN);
    endtask

    function automatic logic [15:0] pick_seq();
        return ($urandom_range(0, 3) == 0) ? 16'hFFFF - 16'($urandom_range(0, 3))
                                           : 16'($urandom);
    endfunction

    function automatic logic [31:0] pick_ts();
        return ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 10000)
                                           : $urandom;
    endfunction

    task automatic randomize_registers();
        int unsigned r;
        logic [1:0]  fmt;
        r = $urandom_range(0, 9);
        write_reg(REG_BPP, (r == 0) ? 32'd0 : (r == 1) ? 32'd31 : (r == 2) ? 32'd18
                                    : $urandom_range(1, 6));
        r = $urandom_range(0, 9);
        write_reg(REG_DROP, (r == 0) ? 32'd0 : (r == 1) ? 32'd255
                          : (r < 5) ? $urandom_range(2, 4) : 32'd1);
        r = $urandom_range(0, 9);
        write_reg(REG_REDUN, (r == 0) ? 32'd15 : (r == 1) ? 32'd8
                           : (r < 5) ? $urandom_range(1, 3) : 32'd0);
        r = $urandom_range(0, 9);
        fmt = (r < 4) ? FMT_NTSC : (r < 8) ? FMT_PAL : 2'($urandom_range(2, 3));
        write_reg(REG_MODE, {27'd0, fmt, 3'($urandom_range(0, 7))});
        write_reg(REG_MSEQ, {16'd0, pick_seq()});
        write_reg(REG_ASEQ, {16'd0, pick_seq()});
        write_reg(REG_MTS, pick_ts());
        write_reg(REG_ATS, pick_ts());
    endtask

    // Mostly short frames of random blocks closed by the frame-ending video block,
    // mixed with unconstrained IDs. The last phase runs without any idling.
    task automatic test_random_traffic();
        int          sent;
        int          len;
        int unsigned r;
        logic [2:0]  sct;
        for (int phase = 0; phase < 6; phase++) begin
            wait_results_done(8);
            randomize_registers();
            send_gaps   = (phase < 5);
            sink_stalls = (phase < 5);
            sent = 0;
            while (sent < 30) begin
                if (phase == 2 && sent >= 17 && sent < 20)
                    wait_results_done(0);      // sender holds until all results are out
                if ($urandom_range(0, 4) == 0) begin
                    send_dif_id(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
                                8'($urandom_range(0, 255)));
                    sent++;
                end else begin
                    len = $urandom_range(2, 10);
                    for (int k = 0; k < len; k++) begin
                        r = $urandom_range(0, 9);
                        sct = (r < 3) ? 3'(r) : (r < 6) ? SCT_AUDIO : SCT_VIDEO;
                        send_dif_id(sct, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
                        sent++;
                    end
                    send_dif_id(SCT_VIDEO,
                                (cfg_mode[4:3] == FMT_PAL) ? PAL_LAST_SEQ : NTSC_LAST_SEQ,
                                LAST_DBN);
                    sent++;
                end
            end
        end
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        test_reset_defaults();
        test_redundant_audio();
        test_separate_audio();
        test_frame_drop();
        test_random_traffic();
        wait_results_done(20);
        if (mismatch_count == 0) begin
            $display("dv_dif_rtp_packetizer_top test passed");
        end else begin
            $display("dv_dif_rtp_packetizer_top test failed");
        end
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial begin
        #4000000;
        $display("dv_dif_rtp_packetizer_top test failed");
        $finish;
    end

endmodule
